// ===== rtl/core/lde_pkg.sv =====
`timescale 1ns / 1ps

package lde_pkg;

  // Envelope stage, one-hot
  typedef enum logic [5:0] {
    ST_OFF     = 6'b000001,
    ST_DELAY   = 6'b000010,
    ST_ATTACK  = 6'b000100,
    ST_DECAY   = 6'b001000,
    ST_SUSTAIN = 6'b010000,
    ST_RELEASE = 6'b100000
  } stage_t;

  // Per-sample sequencer, one-hot
  typedef enum logic [4:0] {
    SQ_IDLE  = 5'b00001,
    SQ_PREP  = 5'b00010,
    SQ_DIV   = 5'b00100,
    SQ_APPLY = 5'b01000,
    SQ_MUL   = 5'b10000
  } seq_t;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_DELAY   = 3'd0;
  localparam logic [2:0] REG_ATTACK  = 3'd1;
  localparam logic [2:0] REG_DECAY   = 3'd2;
  localparam logic [2:0] REG_SUSTAIN = 3'd3;
  localparam logic [2:0] REG_RELEASE = 3'd4;
  localparam logic [2:0] REG_LOOP    = 3'd5;
  localparam logic [2:0] REG_LEVEL   = 3'd6;

  localparam logic [16:0] Q16_ONE = 17'd65536;

endpackage

// ===== rtl/core/linear_dadsr_envelope_core.sv =====
`timescale 1ns / 1ps
// A gate sample accepted in SQ_IDLE passes through SQ_PREP, SQ_DIV (only when the stage
// needs a step division), SQ_APPLY and SQ_MUL before the envelope output becomes valid.
// A new sample is accepted only back in SQ_IDLE; the serial ceiling divider, one bit per
// cycle, sets the pace. A waiting result holds only the final output step.
// Reset (rst, synchronous, active high) clears envelope state, stage and output valid
// and loads the register defaults.
module linear_dadsr_envelope_core #(
  parameter int ENV_FRAC_BITS = 24,
  parameter int TIME_BITS     = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        gate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] envelope,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int EW = ENV_FRAC_BITS + 1;
  localparam int TB = TIME_BITS;
  localparam int DW = ((EW > TB) ? EW : TB) + 1;
  localparam logic [EW-1:0] ENV_ONE = {1'b1, {ENV_FRAC_BITS{1'b0}}};
  localparam logic [63:0] NZ64 = (64'd1 << ENV_FRAC_BITS) / 64'd1000000;
  localparam logic [EW-1:0] NEAR_ZERO = NZ64[EW-1:0];
  localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};

  // Configuration
  logic [TB-1:0] delay_samples;
  logic [TB-1:0] attack_samples;
  logic [TB-1:0] decay_samples;
  logic [16:0]   sustain_level;
  logic [TB-1:0] release_samples;
  logic          loop_enable;
  logic [16:0]   output_level;

  // Envelope state
  lde_pkg::seq_t   seq;
  lde_pkg::stage_t stage;
  logic [EW-1:0]   env_value;
  logic [TB-1:0]   delay_count;
  logic [EW-1:0]   release_step;
  logic            previous_gate;
  logic            fall_r;

  logic            wr_en;
  logic [16:0]     sus17;
  logic [16:0]     lvl;
  logic [EW-1:0]   sus_env;
  logic            rise;
  logic            fall;
  logic            need_div;
  logic [EW-1:0]   div_num;
  logic [TB-1:0]   div_den;
  logic [TB-1:0]   den1;
  logic [DW-1:0]   dividend;
  logic            div_start;
  logic            div_done;
  logic [DW-1:0]   div_quo;
  logic [EW-1:0]   step;
  logic [TB-1:0]   dc_inc;
  logic [EW:0]     att_sum;
  logic [EW-1:0]   dec_val;
  logic [EW-1:0]   rel_val;
  logic [EW-1:0]   env_sat;
  logic [EW+16:0]  prod;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples   <= '0;
      attack_samples  <= TB'(3840);
      decay_samples   <= TB'(10560);
      sustain_level   <= 17'd36045;
      release_samples <= TB'(21600);
      loop_enable     <= 1'b0;
      output_level    <= lde_pkg::Q16_ONE;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        lde_pkg::REG_DELAY:   delay_samples   <= pwdata[TB-1:0];
        lde_pkg::REG_ATTACK:  attack_samples  <= pwdata[TB-1:0];
        lde_pkg::REG_DECAY:   decay_samples   <= pwdata[TB-1:0];
        lde_pkg::REG_SUSTAIN: sustain_level   <= pwdata[16:0];
        lde_pkg::REG_RELEASE: release_samples <= pwdata[TB-1:0];
        lde_pkg::REG_LOOP:    loop_enable     <= pwdata[0];
        lde_pkg::REG_LEVEL:   output_level    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      lde_pkg::REG_DELAY:   prdata = 32'(delay_samples);
      lde_pkg::REG_ATTACK:  prdata = 32'(attack_samples);
      lde_pkg::REG_DECAY:   prdata = 32'(decay_samples);
      lde_pkg::REG_SUSTAIN: prdata = 32'(sustain_level);
      lde_pkg::REG_RELEASE: prdata = 32'(release_samples);
      lde_pkg::REG_LOOP:    prdata = 32'(loop_enable);
      lde_pkg::REG_LEVEL:   prdata = 32'(output_level);
      default:              prdata = '0;
    endcase
  end

  // Clamp Q16 levels above one
  assign sus17   = (sustain_level > lde_pkg::Q16_ONE) ? lde_pkg::Q16_ONE : sustain_level;
  assign lvl     = (output_level > lde_pkg::Q16_ONE) ? lde_pkg::Q16_ONE : output_level;
  assign sus_env = EW'(sus17) << (ENV_FRAC_BITS - 16);

  assign in_ready = (seq == lde_pkg::SQ_IDLE);
  assign rise     = !previous_gate && gate;
  assign fall     = previous_gate && !gate;

  // Step division operands: release step on a falling gate, else the ramp step
  assign need_div = fall_r || (stage == lde_pkg::ST_ATTACK) || (stage == lde_pkg::ST_DECAY);

  always_comb begin
    priority if (fall_r) begin
      div_num = env_value;
      div_den = release_samples;
    end else if (stage == lde_pkg::ST_ATTACK) begin
      div_num = ENV_ONE;
      div_den = attack_samples;
    end else begin
      div_num = ENV_ONE - sus_env;
      div_den = decay_samples;
    end
    den1     = (div_den == '0) ? TB'(1) : div_den;
    dividend = DW'(div_num) + DW'(den1) - DW'(1);
  end

  assign div_start = (seq == lde_pkg::SQ_PREP) && need_div;

  lde_div #(
    .NW(DW),
    .DW(TB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (den1),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    step    = div_quo[EW-1:0];
    dc_inc  = (delay_count < TIME_MAX) ? delay_count + 1'b1 : delay_count;
    att_sum = {1'b0, env_value} + {1'b0, step};
    dec_val = (env_value > step) ? env_value - step : '0;
    rel_val = (env_value > release_step) ? env_value - release_step : '0;
    env_sat = (env_value > ENV_ONE) ? ENV_ONE : env_value;
    prod    = (EW + 17)'(env_sat) * (EW + 17)'(lvl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= lde_pkg::SQ_IDLE;
      stage         <= lde_pkg::ST_OFF;
      env_value     <= '0;
      delay_count   <= '0;
      release_step  <= '0;
      previous_gate <= 1'b0;
      fall_r        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // load a new result when the output register is free, else drop an accepted one
      if ((seq == lde_pkg::SQ_MUL) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (seq)
        lde_pkg::SQ_IDLE: begin
          if (in_valid) begin
            previous_gate <= gate;
            fall_r        <= fall;
            seq           <= lde_pkg::SQ_PREP;
            if (rise) begin
              if (delay_samples == '0) begin
                if (attack_samples <= TB'(1)) begin
                  stage     <= lde_pkg::ST_DECAY;
                  env_value <= ENV_ONE;
                end else begin
                  stage <= lde_pkg::ST_ATTACK;
                end
              end else begin
                // retrigger above the near-zero mark keeps value and count
                if (env_value <= NEAR_ZERO) begin
                  env_value   <= '0;
                  delay_count <= '0;
                end
                stage <= lde_pkg::ST_DELAY;
              end
            end else if (fall) begin
              stage <= lde_pkg::ST_RELEASE;
            end
          end
        end
        lde_pkg::SQ_PREP: begin
          seq <= need_div ? lde_pkg::SQ_DIV : lde_pkg::SQ_APPLY;
        end
        lde_pkg::SQ_DIV: begin
          if (div_done) begin
            if (fall_r) begin
              release_step <= div_quo[EW-1:0];
            end
            seq <= lde_pkg::SQ_APPLY;
          end
        end
        lde_pkg::SQ_APPLY: begin
          seq <= lde_pkg::SQ_MUL;
          unique case (stage)
            lde_pkg::ST_DELAY: begin
              if (dc_inc >= delay_samples) begin
                delay_count <= '0;
                if (attack_samples <= TB'(1)) begin
                  stage     <= lde_pkg::ST_DECAY;
                  env_value <= ENV_ONE;
                end else begin
                  stage <= lde_pkg::ST_ATTACK;
                end
              end else begin
                delay_count <= dc_inc;
              end
            end
            lde_pkg::ST_ATTACK: begin
              if (att_sum >= {1'b0, ENV_ONE}) begin
                env_value <= ENV_ONE;
                stage     <= lde_pkg::ST_DECAY;
              end else begin
                env_value <= att_sum[EW-1:0];
              end
            end
            lde_pkg::ST_DECAY: begin
              if (dec_val <= sus_env) begin
                env_value <= sus_env;
                stage     <= lde_pkg::ST_SUSTAIN;
              end else begin
                env_value <= dec_val;
              end
            end
            lde_pkg::ST_SUSTAIN: begin
              if (loop_enable) begin
                stage <= lde_pkg::ST_ATTACK;
              end
              env_value <= sus_env;
            end
            lde_pkg::ST_RELEASE: begin
              env_value <= rel_val;
              if (rel_val == '0) begin
                stage       <= lde_pkg::ST_OFF;
                delay_count <= '0;
              end
            end
            lde_pkg::ST_OFF: ;
            default: ;
          endcase
        end
        lde_pkg::SQ_MUL: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            seq <= lde_pkg::SQ_IDLE;
          end
        end
        default: seq <= lde_pkg::SQ_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((seq == lde_pkg::SQ_MUL) && (!out_valid || out_ready)) begin
      envelope <= prod[ENV_FRAC_BITS+16:ENV_FRAC_BITS];
    end
  end

endmodule

// ===== rtl/core/lde_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lde_div #(
  parameter int NW = 26,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[NW-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/core/lde_checker.sv =====
`timescale 1ns / 1ps

module lde_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] envelope
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(envelope))
    else $error("result changed or dropped while stalled");

  // A sample in progress holds in_ready low; no back-to-back accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("gate accepted while a sample is in progress");

  // Reset clears the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Envelope never exceeds full scale
  a_full_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> envelope <= lde_pkg::Q16_ONE)
    else $error("envelope above full scale");

endmodule

bind linear_dadsr_envelope_core lde_checker u_lde_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .envelope  (envelope)
);

// ===== tb/linear_dadsr_envelope_core_tb.sv =====
`timescale 1ns / 1ps

module linear_dadsr_envelope_core_tb;

  localparam int          CYCLE_LIMIT = 500000;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [63:0] ENV_ONE     = 64'd1 << 24;
  localparam logic [63:0] NEAR_ZERO   = ENV_ONE / 64'd1000000;
  localparam logic [23:0] TIME_MAX    = 24'hFFFFFF;
  // Index past the last register; writes there must change nothing
  localparam logic [2:0]  REG_UNUSED  = 3'd7;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        gate      = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] envelope;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [4:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted register contents
  logic [23:0] cfg_delay   = 24'd0;
  logic [23:0] cfg_attack  = 24'd3840;
  logic [23:0] cfg_decay   = 24'd10560;
  logic [16:0] cfg_sustain = 17'd36045;
  logic [23:0] cfg_release = 24'd21600;
  logic        cfg_loop    = 1'b0;
  logic [16:0] cfg_level   = 17'd65536;

  // Predicted envelope state
  logic [63:0]     env_acc   = '0;
  lde_pkg::stage_t env_stage = lde_pkg::ST_OFF;
  logic [23:0]     delay_cnt = '0;
  logic [63:0]     rel_step  = '0;
  logic            last_gate = 1'b0;

  logic [16:0] pending_envelopes[$];
  int          mismatches    = 0;
  int          cycle_count   = 0;
  int          burst_left    = 0;
  int          hold_requests = 0;
  int          holds_served  = 0;
  int          hold_left     = 0;
  int          ready_mode    = 0;
  int          mode_left     = 0;

  linear_dadsr_envelope_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .gate     (gate),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .envelope (envelope),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] ceil_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] d;
    d = (den == 64'd0) ? 64'd1 : den;
    return (num + d - 64'd1) / d;
  endfunction

  function automatic logic [16:0] envelope_for_gate(input logic g);
    logic [63:0] sus;
    logic [63:0] lvl;
    logic [63:0] env;
    logic [63:0] dec;
    sus = 64'((cfg_sustain > lde_pkg::Q16_ONE) ? lde_pkg::Q16_ONE : cfg_sustain) << 8;
    lvl = 64'((cfg_level > lde_pkg::Q16_ONE) ? lde_pkg::Q16_ONE : cfg_level);

    if (!last_gate && g) begin
      if (cfg_delay == 24'd0) begin
        if (cfg_attack <= 24'd1) begin
          env_stage = lde_pkg::ST_DECAY;
          env_acc = ENV_ONE;
        end else begin
          env_stage = lde_pkg::ST_ATTACK;
        end
      end else begin
        // retrigger above the near-zero mark keeps value and delay count
        if (env_acc <= NEAR_ZERO) begin
          env_acc = '0;
          delay_cnt = '0;
        end
        env_stage = lde_pkg::ST_DELAY;
      end
    end else if (last_gate && !g) begin
      env_stage = lde_pkg::ST_RELEASE;
      rel_step = ceil_div(env_acc, 64'(cfg_release));
    end
    last_gate = g;

    case (env_stage)
      lde_pkg::ST_DELAY: begin
        if (delay_cnt < TIME_MAX) delay_cnt = delay_cnt + 24'd1;
        if (delay_cnt >= cfg_delay) begin
          delay_cnt = '0;
          if (cfg_attack <= 24'd1) begin
            env_stage = lde_pkg::ST_DECAY;
            env_acc = ENV_ONE;
          end else begin
            env_stage = lde_pkg::ST_ATTACK;
          end
        end
      end
      lde_pkg::ST_ATTACK: begin
        env_acc = env_acc + ceil_div(ENV_ONE, 64'(cfg_attack));
        if (env_acc >= ENV_ONE) begin
          env_acc = ENV_ONE;
          env_stage = lde_pkg::ST_DECAY;
        end
      end
      lde_pkg::ST_DECAY: begin
        dec = ceil_div(ENV_ONE - sus, 64'(cfg_decay));
        env_acc = (env_acc > dec) ? env_acc - dec : 64'd0;
        if (env_acc <= sus) begin
          env_acc = sus;
          env_stage = lde_pkg::ST_SUSTAIN;
        end
      end
      lde_pkg::ST_SUSTAIN: begin
        if (cfg_loop) env_stage = lde_pkg::ST_ATTACK;
        env_acc = sus;
      end
      lde_pkg::ST_RELEASE: begin
        env_acc = (env_acc > rel_step) ? env_acc - rel_step : 64'd0;
        if (env_acc == 64'd0) begin
          env_stage = lde_pkg::ST_OFF;
          delay_cnt = '0;
        end
      end
      default: ;
    endcase

    env = (env_acc > ENV_ONE) ? ENV_ONE : env_acc;
    return 17'((env * lvl) >> 24);
  endfunction

  // Result checker
  always @(posedge clk) begin : check_results
    logic [16:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_envelopes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected envelope transaction: got %0d with nothing pending", envelope);
      end else begin
        want = pending_envelopes.pop_front();
        if (envelope !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("envelope mismatch: expected %0d, got %0d", want, envelope);
        end
      end
    end
  end

  // Receiver: random stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_gate(input logic g);
    in_valid <= 1'b1;
    gate <= g;
    do @(posedge clk); while (!in_ready);
    pending_envelopes.push_back(envelope_for_gate(g));
  endtask

  task automatic send_pattern(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_gate(bits[i]);
  endtask

  // Bursts of random length separated by random gaps
  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_envelopes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lde_pkg::REG_DELAY:   cfg_delay = val[23:0];
      lde_pkg::REG_ATTACK:  cfg_attack = val[23:0];
      lde_pkg::REG_DECAY:   cfg_decay = val[23:0];
      lde_pkg::REG_SUSTAIN: cfg_sustain = val[16:0];
      lde_pkg::REG_RELEASE: cfg_release = val[23:0];
      lde_pkg::REG_LOOP:    cfg_loop = val[0];
      lde_pkg::REG_LEVEL:   cfg_level = val[16:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] random_q16();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd65536;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  task automatic test_defaults();
    send_pattern(4'b1100, 4);
  endtask

  // Zero attack jumps to full; sustain and level above one clamp; loop restarts attack
  task automatic test_jump_and_clamp();
    write_reg(lde_pkg::REG_DELAY, 32'd0);
    write_reg(lde_pkg::REG_ATTACK, 32'd0);
    write_reg(lde_pkg::REG_DECAY, 32'd1);
    write_reg(lde_pkg::REG_SUSTAIN, 32'h1FFFF);
    write_reg(lde_pkg::REG_RELEASE, 32'd0);
    write_reg(lde_pkg::REG_LOOP, 32'd1);
    write_reg(lde_pkg::REG_LEVEL, 32'h1FFFF);
    send_pattern(5'b11100, 5);
  endtask

  // Retrigger during release keeps the value through the delay
  task automatic test_retrigger();
    write_reg(lde_pkg::REG_DELAY, 32'd2);
    write_reg(lde_pkg::REG_ATTACK, 32'd1);
    write_reg(lde_pkg::REG_DECAY, 32'd2);
    write_reg(lde_pkg::REG_SUSTAIN, 32'd32768);
    write_reg(lde_pkg::REG_RELEASE, 32'd3);
    write_reg(lde_pkg::REG_LOOP, 32'd0);
    write_reg(lde_pkg::REG_LEVEL, 32'd65536);
    send_pattern(8'b11111011, 8);
  endtask

  task automatic test_longest_times();
    write_reg(lde_pkg::REG_DELAY, 32'hFFFFFF);
    write_reg(lde_pkg::REG_ATTACK, 32'hFFFFFF);
    write_reg(lde_pkg::REG_DECAY, 32'hFFFFFF);
    write_reg(lde_pkg::REG_RELEASE, 32'hFFFFFF);
    write_reg(lde_pkg::REG_LEVEL, 32'd0);
    write_reg(REG_UNUSED, 32'h00FF_FFFF);
    send_pattern(4'b1100, 4);
    write_reg(lde_pkg::REG_DELAY, 32'd0);
    write_reg(lde_pkg::REG_LEVEL, 32'd65536);
    send_pattern(3'b110, 3);
  endtask

  // Hold the output off so the block fills up, then drain completely
  task automatic test_backpressure();
    write_reg(lde_pkg::REG_DELAY, 32'd1);
    write_reg(lde_pkg::REG_ATTACK, 32'd5);
    write_reg(lde_pkg::REG_DECAY, 32'd5);
    write_reg(lde_pkg::REG_SUSTAIN, 32'd20000);
    write_reg(lde_pkg::REG_RELEASE, 32'd5);
    write_reg(lde_pkg::REG_LOOP, 32'd0);
    write_reg(lde_pkg::REG_LEVEL, 32'd50000);
    @(posedge clk);
    hold_requests <= hold_requests + 1;
    send_pattern(16'hFFC0, 16);
    wait_idle();
  endtask

  task automatic test_random_notes();
    int   n;
    int   high_len;
    int   low_len;
    logic noisy;
    logic g;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(lde_pkg::REG_DELAY,
                ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 6));
      write_reg(lde_pkg::REG_ATTACK, $urandom_range(0, 12));
      write_reg(lde_pkg::REG_DECAY, $urandom_range(0, 12));
      write_reg(lde_pkg::REG_SUSTAIN, random_q16());
      write_reg(lde_pkg::REG_RELEASE, $urandom_range(0, 12));
      write_reg(lde_pkg::REG_LOOP, $urandom_range(0, 1));
      write_reg(lde_pkg::REG_LEVEL, random_q16());
      n = 0;
      while (n < 60) begin
        high_len = $urandom_range(1, 30);
        low_len  = $urandom_range(1, 20);
        noisy    = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < high_len + low_len; i++) begin
          g = noisy ? 1'($urandom_range(0, 1)) : (i < high_len);
          send_gate(g);
          pace();
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_jump_and_clamp();
    test_retrigger();
    test_longest_times();
    test_backpressure();
    test_random_notes();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_envelopes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
